@@ rtl/mmps_pkg.sv @@
// ----------------------------------------------------------------------------
// mmps_pkg
// Shared types and constants of the masked multi-pattern byte scanner.
// ----------------------------------------------------------------------------
package mmps_pkg;

  localparam int RESULT_CAP = 8;
  localparam logic [7:0] BYTE_MASK = 8'hFF;

  typedef enum logic [1:0] {
    FUNC_PAT_BYTE = 2'd0,
    FUNC_PAT_LEN  = 2'd1,
    FUNC_REGION   = 2'd2,
    FUNC_DATA     = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WIN,
    ST_CMP,
    ST_EMIT
  } state_t;

  // pattern byte write broadcast to the cell row
  typedef struct packed {
    logic       en;
    logic [2:0] slot;
    logic [4:0] pos;
    logic [7:0] value;
    logic [7:0] mask;
  } pat_wr_t;

endpackage

@@ rtl/mmps_if.sv @@
// ----------------------------------------------------------------------------
// mmps_in_if / mmps_out_if
// Valid/ready channels carrying scanner input items and match results.
// ----------------------------------------------------------------------------
interface mmps_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [2:0]  pattern_slot;
  logic [4:0]  byte_pos;
  logic [7:0]  pattern_value;
  logic [7:0]  pattern_mask;
  logic [5:0]  pattern_length;
  logic [7:0]  match_delta;
  logic [31:0] region_base;
  logic [7:0]  data_byte;

  modport source (output valid, func, pattern_slot, byte_pos, pattern_value, pattern_mask,
                  pattern_length, match_delta, region_base, data_byte, input ready);
  modport sink   (input valid, func, pattern_slot, byte_pos, pattern_value, pattern_mask,
                  pattern_length, match_delta, region_base, data_byte, output ready);
endinterface

interface mmps_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  match_slot;
  logic [31:0] match_offset;
  logic        last_match;

  modport source (output valid, match_slot, match_offset, last_match, input ready);
  modport sink   (input valid, match_slot, match_offset, last_match, output ready);
endinterface

@@ rtl/masked_multi_pattern_byte_scan_top.sv @@
// ----------------------------------------------------------------------------
// masked_multi_pattern_byte_scan_top
// Masked multi-pattern scanner: a row of window cells compares every loaded
// pattern in parallel and matches are reported lowest slot first.
// ----------------------------------------------------------------------------
//  channel   dir  handshake          payload
//  in_bus    in   valid/ready        func, slot, pos, value, mask, length, delta,
//                                    region base, data byte
//  out_bus   out  valid/ready        match_slot, match_offset, last_match
//
//  Pattern byte and region beats are taken in ST_IDLE. A length beat rescans
//  the window size one slot per cycle. A data beat is compared in ST_CMP,
//  then one match is reported per out_bus beat taken (at most 8). Reset
//  clears lengths, deltas, window and counters; pattern bytes are not
//  cleared. in_bus.ready is low while a beat is worked or results wait.
// ----------------------------------------------------------------------------
module masked_multi_pattern_byte_scan_top
  import mmps_pkg::*;
#(
  parameter int NUM_PATTERNS = 8,
  parameter int MAX_LEN      = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  mmps_in_if.sink           in_bus,
  mmps_out_if.source        out_bus
);
  localparam int IDX_W = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int SW    = (NUM_PATTERNS > 1) ? $clog2(NUM_PATTERNS) : 1;

  state_t state_r, state_nxt;

  logic [5:0]              lens_r   [NUM_PATTERNS];
  logic [7:0]              deltas_r [NUM_PATTERNS];
  logic [5:0]              win_r;
  logic [IDX_W-1:0]        off_r;
  logic [SW-1:0]           scan_r;
  logic [31:0]             seen_r;
  logic [31:0]             base_r;
  logic [31:0]             start_r;
  logic [NUM_PATTERNS-1:0] hits_r;
  logic [2:0]              cnt_r;

  logic                    in_acc, out_acc;
  func_t                   func;
  pat_wr_t                 pat_wr;
  logic [5:0]              len_sat;
  logic [5:0]              win_next;
  logic [7:0]              win_b [MAX_LEN];
  logic [NUM_PATTERNS-1:0] cell_hit [MAX_LEN];
  logic [NUM_PATTERNS-1:0] slot_hit;
  logic                    test_ok;
  logic [NUM_PATTERNS-1:0] low_hot, rest;
  logic [SW-1:0]           sel;
  logic                    last;

  assign func    = func_t'(in_bus.func);
  assign in_acc  = in_bus.valid && in_bus.ready;
  assign out_acc = out_bus.valid && out_bus.ready;

  assign pat_wr.en    = in_acc && (func == FUNC_PAT_BYTE)
                        && (int'(in_bus.pattern_slot) < NUM_PATTERNS);
  assign pat_wr.slot  = in_bus.pattern_slot;
  assign pat_wr.pos   = in_bus.byte_pos;
  assign pat_wr.value = in_bus.pattern_value;
  assign pat_wr.mask  = in_bus.pattern_mask;

  // cell row: newest byte enters at the top and moves down one cell per beat
  for (genvar i = 0; i < MAX_LEN; i++) begin : g_cell
    logic [7:0] sh_in;
    if (i == MAX_LEN - 1) begin : g_top
      assign sh_in = in_bus.data_byte;
    end else begin : g_mid
      assign sh_in = win_b[i+1];
    end
    mmps_cell #(
      .NUM_PATTERNS (NUM_PATTERNS),
      .MAX_LEN      (MAX_LEN),
      .CELL_IDX     (i)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .shift_en (in_acc && (func == FUNC_DATA)),
      .shift_in (sh_in),
      .win_byte (win_b[i]),
      .pat_wr   (pat_wr),
      .win_all  (win_b),
      .off      (off_r),
      .lens     (lens_r),
      .hit      (cell_hit[i])
    );
  end

  always_comb begin
    for (int s = 0; s < NUM_PATTERNS; s++) begin
      slot_hit[s] = (lens_r[s] != 6'd0);
      for (int i = 0; i < MAX_LEN; i++) begin
        slot_hit[s] = slot_hit[s] & cell_hit[i][s];
      end
    end
  end

  assign len_sat  = (int'(in_bus.pattern_length) > MAX_LEN) ? 6'(MAX_LEN)
                                                            : in_bus.pattern_length;
  assign win_next = (lens_r[scan_r] > win_r) ? lens_r[scan_r] : win_r;
  assign test_ok  = (win_r != 6'd0) && (seen_r >= {26'd0, win_r});

  // lowest pending slot
  assign low_hot = hits_r & (~hits_r + 1'b1);
  assign rest    = hits_r & ~low_hot;
  always_comb begin
    sel = '0;
    for (int s = 0; s < NUM_PATTERNS; s++) begin
      if (low_hot[s]) begin
        sel = sel | SW'(s);
      end
    end
  end
  assign last = (rest == '0) || (int'(cnt_r) == RESULT_CAP - 1);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc && (func == FUNC_PAT_LEN)
            && (int'(in_bus.pattern_slot) < NUM_PATTERNS)) begin
          state_nxt = ST_WIN;
        end else if (in_acc && (func == FUNC_DATA)) begin
          state_nxt = ST_CMP;
        end
      end
      ST_WIN: begin
        if (int'(scan_r) == NUM_PATTERNS - 1) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_CMP: begin
        state_nxt = (test_ok && (slot_hit != '0)) ? ST_EMIT : ST_IDLE;
      end
      ST_EMIT: begin
        if (out_acc && last) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_bus.ready         = (state_r == ST_IDLE);
    out_bus.valid        = (state_r == ST_EMIT);
    out_bus.match_slot   = 3'(sel);
    out_bus.match_offset = start_r - {24'd0, deltas_r[sel]};
    out_bus.last_match   = last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      win_r   <= '0;
      off_r   <= '0;
      scan_r  <= '0;
      seen_r  <= '0;
      base_r  <= '0;
      hits_r  <= '0;
      cnt_r   <= '0;
      for (int s = 0; s < NUM_PATTERNS; s++) begin
        lens_r[s]   <= '0;
        deltas_r[s] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            case (func)
              FUNC_PAT_LEN: begin
                if (int'(in_bus.pattern_slot) < NUM_PATTERNS) begin
                  lens_r[SW'(in_bus.pattern_slot)]   <= len_sat;
                  deltas_r[SW'(in_bus.pattern_slot)] <= in_bus.match_delta;
                  win_r  <= '0;
                  scan_r <= '0;
                end
              end
              FUNC_REGION: begin
                base_r <= in_bus.region_base;
                seen_r <= '0;
              end
              FUNC_DATA: seen_r <= seen_r + 32'd1;
              default: ;
            endcase
          end
        end
        ST_WIN: begin
          // rescan slot lengths for the window size
          win_r  <= win_next;
          scan_r <= scan_r + 1'b1;
          if (int'(scan_r) == NUM_PATTERNS - 1) begin
            off_r <= IDX_W'(MAX_LEN - int'(win_next));
          end
        end
        ST_CMP: begin
          hits_r  <= test_ok ? slot_hit : '0;
          start_r <= base_r + seen_r - {26'd0, win_r};
          cnt_r   <= '0;
        end
        ST_EMIT: begin
          if (out_acc) begin
            hits_r <= rest;
            cnt_r  <= cnt_r + 3'd1;
          end
        end
        default: ;
      endcase
    end
  end

  a_emit_has_hit: assert property (@(posedge clk) disable iff (!rst_n)
    out_bus.valid |-> (hits_r != '0))
    else $error("result shown with no pending match");

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    in_bus.ready |-> !out_bus.valid)
    else $error("input taken while results pending");

  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (out_bus.valid && out_bus.ready && out_bus.last_match) |=> (state_r == ST_IDLE))
    else $error("results continue after last beat");

  a_win_bound: assert property (@(posedge clk) disable iff (!rst_n)
    int'(win_r) <= MAX_LEN)
    else $error("window size above maximum");

endmodule

@@ rtl/mmps_cell.sv @@
// ----------------------------------------------------------------------------
// mmps_cell
// One window position: holds a window byte, passes it down the row on each
// data beat, and holds pattern byte CELL_IDX of every slot for comparison.
// ----------------------------------------------------------------------------
module mmps_cell
  import mmps_pkg::*;
#(
  parameter int NUM_PATTERNS = 8,
  parameter int MAX_LEN      = 32,
  parameter int CELL_IDX     = 0,
  localparam int IDX_W       = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      shift_en,
  input  logic [7:0]                shift_in,
  output logic [7:0]                win_byte,
  input  pat_wr_t                   pat_wr,
  input  logic [7:0]                win_all [MAX_LEN],
  input  logic [IDX_W-1:0]          off,
  input  logic [5:0]                lens [NUM_PATTERNS],
  output logic [NUM_PATTERNS-1:0]   hit
);
  localparam int SW    = (NUM_PATTERNS > 1) ? $clog2(NUM_PATTERNS) : 1;

  logic [7:0] win_r;
  logic [7:0] val_r  [NUM_PATTERNS];
  logic [7:0] mask_r [NUM_PATTERNS];
  logic [IDX_W:0] src_idx;
  logic [7:0] aligned;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r <= '0;
    end else if (shift_en) begin
      win_r <= shift_in;
    end
  end

  always_ff @(posedge clk) begin
    if (pat_wr.en && (int'(pat_wr.pos) == CELL_IDX)) begin
      val_r[SW'(pat_wr.slot)]  <= pat_wr.value;
      mask_r[SW'(pat_wr.slot)] <= pat_wr.mask;
    end
  end

  assign win_byte = win_r;

  // window byte lined up with this pattern position
  assign src_idx = (IDX_W+1)'(CELL_IDX) + {1'b0, off};
  assign aligned = (int'(src_idx) < MAX_LEN) ? win_all[src_idx[IDX_W-1:0]] : 8'h00;

  always_comb begin
    for (int s = 0; s < NUM_PATTERNS; s++) begin
      hit[s] = (CELL_IDX >= int'(lens[s])) || ((aligned & mask_r[s]) == val_r[s]);
    end
  end

endmodule
